/* sv/ploq_pkg.sv */
// Shared constants, codes and types for the price level order queue.
`default_nettype none

package ploq_pkg;

  localparam int MAX_ORDERS = 64;
  localparam int IDX_W      = $clog2(MAX_ORDERS);
  localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
  localparam int RESULT_CAP = 64;
  localparam int REC_W      = $clog2(RESULT_CAP + 1);
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 38;
  localparam int ID_W       = 32;
  localparam int QTY_W      = 32;
  localparam int PRICE_W    = 32;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_RECORD     = 3'd4,
    ST_NO_RECORDS = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } chain_ctrl_t;

endpackage

`default_nettype wire

/* sv/ploq_cell.sv */
// One queue cell: holds an entry, loads it by index or takes the neighbor's entry on shift.
`default_nettype none

module ploq_cell
  import ploq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire chain_ctrl_t      ctrl,
  input  wire entry_t           nbr,
  output entry_t                q
);

  entry_t data_r;
  entry_t data_nxt;
  logic   sel;

  always_comb begin
    sel = ctrl.wr_en && (ctrl.wr_idx == cell_idx);
    if (sel) begin
      data_nxt = ctrl.wr_data;
    end else if (ctrl.shift) begin
      data_nxt = nbr;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

/* sv/ploq_chain.sv */
// Row of queue cells shifting toward the head, with the head entry exposed.
`default_nettype none

module ploq_chain
  import ploq_pkg::*;
(
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  output entry_t           head
);

  entry_t cell_q [MAX_ORDERS];

  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    entry_t nbr;
    if (i == MAX_ORDERS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    ploq_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctrl     (ctrl),
      .nbr      (nbr),
      .q        (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

`default_nettype wire

/* sv/price_level_order_queue_core.sv */
// Top level of the price level order queue: control sequencer over a chain of cells.
// Add, unused mode, any rejected command: no scan; the done state registers the result strobe.
// Remove and read-out rotate the whole queue once, a cell step per cycle, then the done state
// gives the final result; read-out records appear during the rotation, the last one after it.
// A new command is taken once busy drops; results cannot be stalled by the receiver.
// Synchronous active-low reset empties the queue, clears the total and the level price.
`default_nettype none

module price_level_order_queue_core
  import ploq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_mode,
  input  wire logic [ID_W-1:0]      in_order_id,
  input  wire logic [QTY_W-1:0]     in_quantity,
  input  wire logic                 cfg_wr_en,
  input  wire logic [PRICE_W-1:0]   cfg_wr_data,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [ID_W-1:0]           out_record_id,
  output logic [QTY_W-1:0]          out_record_quantity,
  output logic [PRICE_W-1:0]        out_record_price,
  output logic [POS_W-1:0]          out_record_position,
  output logic [COUNT_W-1:0]        out_order_count,
  output logic [TOTAL_W-1:0]        out_total_quantity,
  output logic                      out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [PRICE_W-1:0]   price_r;
  logic [1:0]           op_r;
  logic [ID_W-1:0]      id_r;
  logic [QTY_W-1:0]     qty_r;
  logic [CNT_W-1:0]     steps_r;
  logic                 found_r;
  status_t              status_r;
  logic                 pend_valid_r;
  entry_t               pend_r;
  logic [POS_W-1:0]     pend_pos_r;
  logic [REC_W-1:0]     rec_cnt_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [ID_W-1:0]      out_id_r;
  logic [QTY_W-1:0]     out_qty_r;
  logic [PRICE_W-1:0]   out_price_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_last_r;

  chain_ctrl_t          ctrl;
  entry_t               head;
  logic                 accept;
  logic                 full;
  logic                 drop;
  logic                 take_rec;
  logic [TOTAL_W:0]     add_sum;
  logic [TOTAL_W-1:0]   add_total;
  logic [TOTAL_W-1:0]   sub_total;

  ploq_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  always_comb begin
    accept    = start && (state_r == S_IDLE);
    full      = (count_r == CNT_W'(MAX_ORDERS));
    add_sum   = {1'b0, total_r} + (TOTAL_W+1)'(in_quantity);
    add_total = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
    sub_total = (total_r > TOTAL_W'(qty_r)) ? (total_r - TOTAL_W'(qty_r)) : '0;
    drop      = (state_r == S_SCAN) && (op_r == MODE_REMOVE) && !found_r && (head.id == id_r);
    take_rec  = (state_r == S_SCAN) && (op_r == MODE_READ) && (head.qty != '0) &&
                (rec_cnt_r < REC_W'(RESULT_CAP));
    ctrl      = '0;
    if (accept && (in_mode == MODE_ADD) && !full) begin
      ctrl.wr_en        = 1'b1;
      ctrl.wr_idx       = count_r[IDX_W-1:0];
      ctrl.wr_data.id   = in_order_id;
      ctrl.wr_data.qty  = in_quantity;
    end else if (state_r == S_SCAN) begin
      ctrl.shift   = 1'b1;
      ctrl.wr_en   = !drop;
      ctrl.wr_idx  = IDX_W'(count_r - CNT_W'(1));
      ctrl.wr_data = head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      price_r      <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      rec_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        price_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= in_mode;
            id_r         <= in_order_id;
            qty_r        <= in_quantity;
            steps_r      <= count_r;
            found_r      <= 1'b0;
            pend_valid_r <= 1'b0;
            rec_cnt_r    <= '0;
            status_r     <= ST_OK;
            state_r      <= S_DONE;
            case (in_mode)
              MODE_ADD: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  count_r <= count_r + CNT_W'(1);
                  total_r <= add_total;
                end
              end
              MODE_REMOVE: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              MODE_READ: begin
                if (count_r != '0) begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
                status_r <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (drop) begin
            found_r <= 1'b1;
            count_r <= count_r - CNT_W'(1);
            total_r <= sub_total;
          end
          if (take_rec) begin
            pend_valid_r <= 1'b1;
            pend_r       <= head;
            pend_pos_r   <= rec_cnt_r[POS_W-1:0];
            rec_cnt_r    <= rec_cnt_r + REC_W'(1);
            if (pend_valid_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_RECORD;
              out_id_r     <= pend_r.id;
              out_qty_r    <= pend_r.qty;
              out_price_r  <= price_r;
              out_pos_r    <= pend_pos_r;
              out_count_r  <= COUNT_W'(count_r);
              out_total_r  <= total_r;
              out_last_r   <= 1'b0;
            end
          end
          steps_r <= steps_r - CNT_W'(1);
          if (steps_r == CNT_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_count_r <= COUNT_W'(count_r);
          out_total_r <= total_r;
          out_last_r  <= 1'b1;
          out_status_r <= status_r;
          out_id_r     <= '0;
          out_qty_r    <= '0;
          out_price_r  <= '0;
          out_pos_r    <= '0;
          if (op_r == MODE_READ) begin
            if (pend_valid_r) begin
              out_status_r <= ST_RECORD;
              out_id_r     <= pend_r.id;
              out_qty_r    <= pend_r.qty;
              out_price_r  <= price_r;
              out_pos_r    <= pend_pos_r;
            end else begin
              out_status_r <= ST_NO_RECORDS;
            end
          end else if ((op_r == MODE_REMOVE) && (status_r == ST_OK)) begin
            out_status_r <= found_r ? ST_OK : ST_NOT_FOUND;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_record_id       = out_id_r;
  assign out_record_quantity = out_qty_r;
  assign out_record_price    = out_price_r;
  assign out_record_position = out_pos_r;
  assign out_order_count     = out_count_r;
  assign out_total_quantity  = out_total_r;
  assign out_last            = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ORDERS))
    else $error("order count beyond queue depth");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (steps_r != '0))
    else $error("rotation running with no steps left");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == S_IDLE))
    else $error("final result while still busy");

  a_no_drop_twice: assert property (@(posedge clk) disable iff (!rst_n)
    drop |=> found_r)
    else $error("removed entry not recorded");
`endif

endmodule

`default_nettype wire
